[rtl/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants for the text console writer
// Command codes, register indexes, character codes and the control and status
// bundle of the decimal converter.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int VALUE_W    = 64;
	localparam int STEP_W     = $clog2(VALUE_W);
	localparam int CMD_W      = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	localparam logic [CMD_W-1:0] CMD_CHAR     = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SIGNED   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_UNSIGNED = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ATTRIBUTE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMNS   = 1'd1;

	localparam logic [7:0] ATTRIBUTE_RESET = 8'd7;
	localparam logic [7:0] COLUMNS_RESET   = 8'd80;

	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	typedef struct packed {
		logic load;
		logic digit_shift;
	} tcw_cvt_ctrl_t;

	typedef struct packed {
		logic       done;
		logic       ovf;
		logic [3:0] top;
	} tcw_cvt_sts_t;

endpackage

[rtl/tcw_if.sv]
// ----------------------------------------------------------------------------
// tcw_if: request and result channels of the text console writer
// Valid/ready channels; a request or result moves when valid and ready are high.
// ----------------------------------------------------------------------------
interface tcw_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [tcw_pkg::CMD_W-1:0]    command;
	logic [tcw_pkg::VALUE_W-1:0]  value;

	modport source(output valid, command, value, input ready);
	modport sink(input valid, command, value, output ready);
endinterface

interface tcw_cell_if;
	logic        valid;
	logic        ready;
	logic        cell_write;
	logic [15:0] cell_address;
	logic [15:0] cell_data;
	logic [15:0] cursor_offset;
	logic        last;

	modport source(output valid, cell_write, cell_address, cell_data, cursor_offset, last,
		input ready);
	modport sink(input valid, cell_write, cell_address, cell_data, cursor_offset, last,
		output ready);
endinterface

[rtl/tcw_dabble.sv]
// ----------------------------------------------------------------------------
// tcw_dabble: iterative binary to decimal converter
// Shift-add-3 over one input bit per cycle; keeps the low MAX_DIGITS digits and
// flags when higher digits were lost. Digits are then read from the top.
// ----------------------------------------------------------------------------
module tcw_dabble #(
	parameter int MAX_DIGITS = 20
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tcw_pkg::tcw_cvt_ctrl_t      ctrl,
	input  logic [tcw_pkg::VALUE_W-1:0] mag,
	output tcw_pkg::tcw_cvt_sts_t       sts
);
	import tcw_pkg::*;

	localparam int BCD_W = 4 * MAX_DIGITS;

	logic              run_q;
	logic [STEP_W-1:0] cnt_q;
	logic [VALUE_W-1:0] bin_q;
	logic [BCD_W-1:0]  bcd_q;
	logic              ovf_q;
	logic [BCD_W-1:0]  adj;

	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
				: bcd_q[4*i +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (ctrl.load) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + STEP_W'(1);
			if (cnt_q == STEP_W'(VALUE_W - 1)) begin
				run_q <= 1'b0;
			end
		end
	end

	// top corrected bit falls off the kept digits: the number is too long
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			bin_q <= mag;
			bcd_q <= '0;
			ovf_q <= 1'b0;
		end else if (run_q) begin
			bin_q <= bin_q << 1;
			bcd_q <= {adj[BCD_W-2:0], bin_q[VALUE_W-1]};
			ovf_q <= ovf_q | adj[BCD_W-1];
		end else if (ctrl.digit_shift) begin
			bcd_q <= bcd_q << 4;
		end
	end

	assign sts.done = run_q && (cnt_q == STEP_W'(VALUE_W - 1));
	assign sts.ovf  = ovf_q;
	assign sts.top  = bcd_q[BCD_W-1 -: 4];

endmodule

[rtl/text_console_writer.sv]
// ----------------------------------------------------------------------------
// text_console_writer: text console cell and cursor writer
// Prints characters and signed or unsigned 64-bit decimals as console cells.
// ----------------------------------------------------------------------------
// Character request: after acceptance, CHAR_A updates the cursor, then CHAR_B registers the result.
// Number request: the shift-add-3 converter (one bit per cycle), then SCAN drops each skipped
//   leading zero, then CHAR_A and CHAR_B for each printed character
//   (address multiply, then offset multiply), CHAR_B waiting for a free result register.
// One request at a time; a new request is taken once the last result is registered.
// Reset: cursor at row 0 column 0, attribute 7, columns 80, no result pending.
module text_console_writer #(
	parameter int MAX_DIGITS = 20,
	parameter int TAB_WIDTH  = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	tcw_cmd_if.sink                        req,
	tcw_cell_if.source                     res,
	input  logic                           cfg_we,
	input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import tcw_pkg::*;

	localparam int PHASE_W = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
	localparam int CNT_W   = $clog2(MAX_DIGITS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SCAN,
		ST_CHAR_A,
		ST_CHAR_B
	} state_t;

	state_t             state_q;
	logic [7:0]         attr_q;
	logic [7:0]         cols_q;
	logic [8:0]         col_q;
	logic [7:0]         row_q;
	logic [PHASE_W-1:0] phase_q;
	logic [7:0]         ch_q;
	logic               num_q;
	logic               sign_q;
	logic [CNT_W-1:0]   rem_q;
	logic [15:0]        addr_q;

	logic        res_valid_q;
	logic        res_cell_write_q;
	logic [15:0] res_cell_address_q;
	logic [15:0] res_cell_data_q;
	logic [15:0] res_cursor_offset_q;
	logic        res_last_q;

	tcw_cvt_ctrl_t      cvt_ctrl;
	tcw_cvt_sts_t       cvt_sts;
	logic [VALUE_W-1:0] mag;
	logic               accept;
	logic               is_neg;
	logic               out_free;
	logic               scan_skip;
	logic               emit;
	logic               digit_adv;
	logic [7:0]         cur_ch;
	logic               cur_last;
	logic               is_ctrl;
	logic [15:0]        lin;
	logic [8:0]         col_mv;
	logic [7:0]         row_mv;
	logic               wrap;
	logic [8:0]         col_nx;
	logic [7:0]         row_nx;
	logic [PHASE_W-1:0] phase_inc;
	logic [PHASE_W-1:0] phase_nx;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign is_neg    = (req.command == CMD_SIGNED) && req.value[VALUE_W-1];
	assign mag       = is_neg ? (VALUE_W'(0) - req.value) : req.value;

	assign out_free  = !res_valid_q || res.ready;
	assign scan_skip = (state_q == ST_SCAN) && !cvt_sts.ovf && (cvt_sts.top == 4'd0)
		&& (rem_q > CNT_W'(1));
	assign emit      = (state_q == ST_CHAR_B) && out_free;
	assign digit_adv = emit && num_q && !sign_q && !cur_last;

	assign cvt_ctrl.load        = accept && ((req.command == CMD_SIGNED)
		|| (req.command == CMD_UNSIGNED));
	assign cvt_ctrl.digit_shift = scan_skip || digit_adv;

	tcw_dabble #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_dabble (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (cvt_ctrl),
		.mag   (mag),
		.sts   (cvt_sts)
	);

	always_comb begin
		if (!num_q) begin
			cur_ch = ch_q;
		end else if (sign_q) begin
			cur_ch = CH_MINUS;
		end else begin
			cur_ch = CH_ZERO + {4'd0, cvt_sts.top};
		end
	end

	assign cur_last = num_q ? (!sign_q && (rem_q == CNT_W'(1))) : 1'b1;
	assign is_ctrl  = (cur_ch == CH_NL) || (cur_ch == CH_CR) || (cur_ch == CH_TAB);

	// shared 8x8 cursor multiply: cell address in CHAR_A, new offset in CHAR_B
	assign lin = 16'(col_q) + 16'(row_q) * 16'(cols_q);

	assign phase_inc = (phase_q == PHASE_W'(TAB_WIDTH - 1)) ? '0 : phase_q + PHASE_W'(1);

	always_comb begin
		case (cur_ch)
			CH_NL: begin
				col_mv = '0;
				row_mv = row_q + 8'd1;
			end
			CH_CR: begin
				col_mv = '0;
				row_mv = row_q;
			end
			CH_TAB: begin
				col_mv = col_q + (9'(TAB_WIDTH) - 9'(phase_q));
				row_mv = row_q;
			end
			default: begin
				col_mv = col_q + 9'd1;
				row_mv = row_q;
			end
		endcase
		wrap     = (col_mv >= {1'b0, cols_q});
		col_nx   = wrap ? 9'd0 : col_mv;
		row_nx   = wrap ? row_mv + 8'd1 : row_mv;
		phase_nx = (wrap || is_ctrl) ? '0 : phase_inc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTRIBUTE_RESET;
			cols_q <= COLUMNS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ATTRIBUTE: attr_q <= cfg_wdata;
				REG_COLUMNS:   cols_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q             <= ST_IDLE;
			col_q               <= '0;
			row_q               <= '0;
			phase_q             <= '0;
			num_q               <= 1'b0;
			sign_q              <= 1'b0;
			rem_q               <= '0;
			ch_q                <= '0;
			addr_q              <= '0;
			res_valid_q         <= 1'b0;
			res_cell_write_q    <= 1'b0;
			res_cell_address_q  <= '0;
			res_cell_data_q     <= '0;
			res_cursor_offset_q <= '0;
			res_last_q          <= 1'b0;
		end else begin
			if (res_valid_q && res.ready && !emit) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.command)
							CMD_CHAR: begin
								ch_q    <= req.value[7:0];
								num_q   <= 1'b0;
								sign_q  <= 1'b0;
								state_q <= ST_CHAR_A;
							end
							CMD_SIGNED, CMD_UNSIGNED: begin
								num_q   <= 1'b1;
								sign_q  <= is_neg;
								rem_q   <= CNT_W'(MAX_DIGITS);
								state_q <= ST_CONV;
							end
							default: ;
						endcase
					end
				end
				ST_CONV: begin
					if (cvt_sts.done) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// drop leading zeros, keeping the last digit, unless the kept digits overflowed
					if (scan_skip) begin
						rem_q <= rem_q - CNT_W'(1);
					end else begin
						state_q <= ST_CHAR_A;
					end
				end
				ST_CHAR_A: begin
					addr_q  <= lin;
					col_q   <= col_nx;
					row_q   <= row_nx;
					phase_q <= phase_nx;
					state_q <= ST_CHAR_B;
				end
				ST_CHAR_B: begin
					// hold until the result register is free
					if (emit) begin
						res_valid_q         <= 1'b1;
						res_cell_write_q    <= !is_ctrl;
						res_cell_address_q  <= is_ctrl ? 16'd0 : addr_q;
						res_cell_data_q     <= is_ctrl ? 16'd0 : {attr_q, cur_ch};
						res_cursor_offset_q <= lin;
						res_last_q          <= cur_last;
						if (cur_last) begin
							state_q <= ST_IDLE;
						end else begin
							if (sign_q) begin
								sign_q <= 1'b0;
							end else begin
								rem_q <= rem_q - CNT_W'(1);
							end
							state_q <= ST_CHAR_A;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res.valid         = res_valid_q;
	assign res.cell_write    = res_cell_write_q;
	assign res.cell_address  = res_cell_address_q;
	assign res.cell_data     = res_cell_data_q;
	assign res.cursor_offset = res_cursor_offset_q;
	assign res.last          = res_last_q;

	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_cell_write_q) |->
		(res_cell_address_q == 16'd0) && (res_cell_data_q == 16'd0))
		else $error("control character result carries cell payload");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && cur_last) |=> (state_q == ST_IDLE) && res_valid_q && res_last_q)
		else $error("final result did not return to idle");

	a_char_direct: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.command == CMD_CHAR)) |=> (state_q == ST_CHAR_A))
		else $error("character request did not go straight to cursor update");

	a_col_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHAR_B) |-> ((col_q < {1'b0, cols_q}) || (col_q == 9'd0)))
		else $error("cursor column left past the column limit");

endmodule
